### rtl/sorted_store_statistics_assert.svh
// Assertion macros for the sorted store statistics block.
// Used by the port-level checker; no other dependencies.
`ifndef SORTED_STORE_STATISTICS_ASSERT_SVH
`define SORTED_STORE_STATISTICS_ASSERT_SVH

// Checked after reset has been released.
`define SSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted store statistics assertion failed");

// Checked on every edge, reset included.
`define SSS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sorted store statistics assertion failed");

`endif

### rtl/sss_pkg.sv
// Shared types and constants for the sorted store statistics block.
// No dependencies.
package sss_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned IndexW  = 6;
    localparam int unsigned TotalW  = 7;
    localparam int unsigned MedW    = 33;
    localparam int unsigned SumW    = 38;
    localparam int unsigned AvgW    = 40;
    localparam int unsigned DivW    = SumW + 8;
    localparam int unsigned StatusW = 2;
    localparam int unsigned SIn     = 40;
    localparam int unsigned MOut    = 216;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
    localparam logic [StatusW-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        SEL_IDX,
        SEL_MHI,
        SEL_MLO,
        SEL_MAX
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    insert;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    div_start;
        logic    out_load;
    } sss_cmd_t;

    typedef struct packed {
        logic div_done;
    } sss_stat_t;

endpackage

### rtl/sss_ctrl.sv
// Controller state machine for the sorted store statistics block.
// Depends on sss_pkg; drives the datapath by command and status structs.
module sss_ctrl
    import sss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output sss_cmd_t  cmd,
    input  sss_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_RD_IDX,
        S_RD_MHI,
        S_RD_MLO,
        S_RD_MAX,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.rd_sel   = SEL_IDX;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_INS;
                end
            end
            S_INS: begin
                cmd.insert = 1'b1;
                state_next = S_RD_IDX;
            end
            S_RD_IDX: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = SEL_IDX;
                cmd.div_start = 1'b1;
                state_next    = S_RD_MHI;
            end
            S_RD_MHI: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_MHI;
                state_next = S_RD_MLO;
            end
            S_RD_MLO: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_MLO;
                state_next = S_RD_MAX;
            end
            S_RD_MAX: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_MAX;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/sss_datapath.sv
// Datapath: sorted cell chain, running sum, read port and serial divider.
// Depends on sss_pkg; commanded by sss_ctrl.
module sss_datapath
    import sss_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sss_cmd_t           cmd,
    output sss_stat_t          stat,
    input  logic               in_op,
    input  logic [ValueW-1:0]  in_value,
    input  logic [IndexW-1:0]  in_index,
    output logic [StatusW-1:0] out_status,
    output logic [MOut-1:0]    out_data
);

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > IndexW) ? CW : IndexW;

    logic signed [ValueW-1:0] cell_reg [DEPTH];
    logic signed [ValueW-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]         le;

    logic [CW-1:0]           count_reg;
    logic [SumW-1:0]         sum_reg;
    logic                    op_reg;
    logic [ValueW-1:0]       value_reg;
    logic [IndexW-1:0]       index_reg;
    logic [StatusW-1:0]      status_reg;
    logic signed [ValueW-1:0] rd_val_reg, mhi_reg, mlo_reg, max_reg;

    logic                    full;
    logic [AW-1:0]           rd_addr;
    logic signed [ValueW-1:0] rd_data;

    // serial divider
    logic [DivW-1:0] div_q_reg;
    logic [CW:0]     div_r_reg;
    logic [5:0]      div_cnt_reg;
    logic            div_busy_reg;
    logic            div_neg_reg;
    logic [CW:0]     div_rs;
    logic [SumW-1:0] sum_mag;
    logic [DivW-1:0] quot;

    logic [StatusW-1:0]  o_status_reg;
    logic [MOut-1:0]     o_data_reg;

    assign full = (count_reg >= CW'(DEPTH));

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k] = (CW'(k) < count_reg) && (cell_reg[k] <= $signed(value_reg));
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (le[k]) begin
                cell_next[k] = cell_reg[k];
            end else if (k == 0) begin
                cell_next[k] = $signed(value_reg);
            end else if (le[k-1]) begin
                cell_next[k] = $signed(value_reg);
            end else begin
                cell_next[k] = cell_reg[k-1];
            end
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            SEL_IDX: rd_addr = AW'(index_reg);
            SEL_MHI: rd_addr = AW'(count_reg >> 1);
            SEL_MLO: rd_addr = AW'((count_reg >> 1) - CW'(1));
            SEL_MAX: rd_addr = AW'(count_reg - CW'(1));
            default: rd_addr = '0;
        endcase
        rd_data = cell_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert && op_reg == OP_INSERT && !full) begin
            for (int k = 0; k < DEPTH; k++) begin
                cell_reg[k] <= cell_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.insert && op_reg == OP_INSERT && !full) begin
            count_reg <= count_reg + CW'(1);
            sum_reg   <= sum_reg + {{(SumW-ValueW){value_reg[ValueW-1]}}, value_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            value_reg <= in_value;
            index_reg <= in_index;
        end
        if (cmd.insert) begin
            if (op_reg == OP_INSERT) begin
                status_reg <= full ? ST_FULL : ST_OK;
            end else if (count_reg == '0) begin
                status_reg <= ST_EMPTY;
            end else if (CMPW'(index_reg) >= CMPW'(count_reg)) begin
                status_reg <= ST_RANGE;
            end else begin
                status_reg <= ST_OK;
            end
        end
        if (cmd.rd_en) begin
            case (cmd.rd_sel)
                SEL_IDX: rd_val_reg <= (op_reg == OP_READ && status_reg == ST_OK)
                                       ? rd_data : '0;
                SEL_MHI: mhi_reg <= rd_data;
                SEL_MLO: mlo_reg <= rd_data;
                SEL_MAX: max_reg <= rd_data;
                default: max_reg <= rd_data;
            endcase
        end
    end

    assign sum_mag = sum_reg[SumW-1] ? (~sum_reg + SumW'(1)) : sum_reg;
    assign div_rs  = {div_r_reg[CW-1:0], div_q_reg[DivW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'(DivW - 1)) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // restoring division of |sum|*256 by the count, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_q_reg   <= {sum_mag, 8'd0};
            div_r_reg   <= '0;
            div_neg_reg <= sum_reg[SumW-1];
        end else if (div_busy_reg) begin
            if (div_rs >= {1'b0, count_reg}) begin
                div_r_reg <= div_rs - {1'b0, count_reg};
                div_q_reg <= {div_q_reg[DivW-2:0], 1'b1};
            end else begin
                div_r_reg <= div_rs;
                div_q_reg <= {div_q_reg[DivW-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = !div_busy_reg;
    assign quot = div_neg_reg ? (~div_q_reg + DivW'(1)) : div_q_reg;

    always_ff @(posedge aclk) begin
        logic signed [MedW-1:0] med;
        med = MedW'(mhi_reg) + (count_reg[0] ? MedW'(mhi_reg) : MedW'(mlo_reg));
        if (cmd.out_load) begin
            o_status_reg <= status_reg;
            if (count_reg == '0) begin
                o_data_reg <= {2'b00, rd_val_reg, {(MOut-2-ValueW){1'b0}}};
            end else begin
                o_data_reg <= {2'b00, rd_val_reg, quot[AvgW-1:0], sum_reg, med,
                               max_reg, cell_reg[0], TotalW'(count_reg)};
            end
        end
    end

    assign out_status = o_status_reg;
    assign out_data   = o_data_reg;

endmodule

### rtl/sorted_store_statistics.sv
// Sorted store statistics, top level.
// Input stream s_*: tuser = op (0 insert, 1 read); tdata = value, index.
// Result stream m_*: tuser = status; tdata = entry_total, minimum, maximum,
//   median_doubled, sum_of_values, average_q8, read_value.
// One result transaction for every input transaction, in order.
// An input is taken only when the block is idle; after the accepting edge
// it runs one insert step, one index read that also starts the 46-step
// serial divider forming the Q8 average (median and maximum reads run
// alongside it), a wait for the divider to finish and a load of the result
// register, which raises m_tvalid. The next input is taken only once the
// block is idle again, so one input is processed at a time.
// An insert into a full store is rejected with status full; a read of an
// empty store or past the count reports status empty or out of range.
// The result register holds while m_tready is low; the next input may be
// accepted meanwhile, but its result waits until the register frees.
// Reset (aresetn low, synchronous) empties the store and clears the sum.
// Depends on sss_pkg, sss_ctrl and sss_datapath.
module sorted_store_statistics
    import sss_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SIn-1:0]     s_tdata,  // value[31:0], index[37:32], zero pad
    input  logic               s_tuser,  // op
    output logic               m_tvalid,
    input  logic               m_tready,
    // entry_total[6:0], minimum[38:7], maximum[70:39], median_doubled[103:71],
    // sum_of_values[141:104], average_q8[181:142], read_value[213:182]
    output logic [MOut-1:0]    m_tdata,
    output logic [StatusW-1:0] m_tuser   // status
);

    sss_cmd_t  cmd;
    sss_stat_t stat;

    sss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sss_datapath #(.DEPTH(DEPTH)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_value   (s_tdata[ValueW-1:0]),
        .in_index   (s_tdata[ValueW+IndexW-1:ValueW]),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

### rtl/sss_checker.sv
// Port-level checker for sorted_store_statistics, with its bind.
// Depends on sss_pkg and sorted_store_statistics_assert.svh.
`include "sorted_store_statistics_assert.svh"

module sss_checker
    import sss_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MOut-1:0]    m_tdata,
    input logic [StatusW-1:0] m_tuser
);

    `SSS_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_tvalid)
    `SSS_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `SSS_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `SSS_ASSERT(a_empty_zero, aclk, aresetn,
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[6:0] == 7'd0 && m_tdata[141:104] == '0)
    `SSS_ASSERT(a_min_le_max, aclk, aresetn,
        m_tvalid && m_tdata[6:0] != 7'd0 |-> $signed(m_tdata[38:7]) <= $signed(m_tdata[70:39]))

endmodule

bind sorted_store_statistics sss_checker u_sss_checker (.*);
